FILE: rtl/core/wsda_pkg.sv
// ----------------------------------------------------------------------------
// Wind averager package
// Shared constants, tables and control types for the wind speed and
// direction averager.
// ----------------------------------------------------------------------------
package wsda_pkg;

    localparam int MaxSamples  = 1024;
    localparam int CntW        = $clog2(MaxSamples + 1);
    localparam int SpeedSumW   = 16 + CntW - 1;
    localparam int TrigSumW    = 16 + CntW;
    localparam int Stages      = 16;
    localparam int StageW      = $clog2(Stages);
    localparam int DivStepW    = $clog2(SpeedSumW + 1);

    localparam logic [14:0] FullTurn    = 15'd23040;
    localparam logic [14:0] HalfTurn    = 15'd11520;
    localparam logic [14:0] QuarterTurn = 15'd5760;
    localparam logic signed [31:0] GainInv = 32'sd652032874;

    // Vectoring word: trig sum times 65536, plus growth headroom.
    localparam int VecW = TrigSumW + 16 + 2;

    function automatic logic signed [24:0] arc(input logic [StageW-1:0] i);
        logic signed [24:0] a;
        case (i)
            4'd0:    a = 25'sd737280;
            4'd1:    a = 25'sd435242;
            4'd2:    a = 25'sd229970;
            4'd3:    a = 25'sd116736;
            4'd4:    a = 25'sd58595;
            4'd5:    a = 25'sd29326;
            4'd6:    a = 25'sd14667;
            4'd7:    a = 25'sd7334;
            4'd8:    a = 25'sd3667;
            4'd9:    a = 25'sd1833;
            4'd10:   a = 25'sd917;
            4'd11:   a = 25'sd458;
            4'd12:   a = 25'sd229;
            4'd13:   a = 25'sd115;
            4'd14:   a = 25'sd57;
            default: a = 25'sd29;
        endcase
        return a;
    endfunction

    typedef struct packed {
        logic load;
        logic rot_init;
        logic rot_step;
        logic accum;
        logic vec_init;
        logic vec_step;
        logic div_init;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic last_step;
        logic div_done;
    } t_status;

endpackage

FILE: rtl/core/wsda_datapath.sv
// ----------------------------------------------------------------------------
// Wind averager datapath
// Running sums, shared CORDIC for rotation and vectoring, and a serial
// restoring divider for the mean speed.
// ----------------------------------------------------------------------------
module wsda_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wsda_pkg::t_cmd      i_cmd,
    output wsda_pkg::t_status   o_status,
    input  logic [15:0]         i_speed,
    input  logic [14:0]         i_heading,
    output logic [15:0]         o_mean_speed,
    output logic [14:0]         o_mean_heading,
    output logic                o_store_full,
    output logic [10:0]         o_sample_count
);

    localparam int CW = wsda_pkg::CntW;
    localparam int SW = wsda_pkg::SpeedSumW;
    localparam int TW = wsda_pkg::TrigSumW;
    localparam int VW = wsda_pkg::VecW;

    logic [CW-1:0]          r_count;
    logic [SW-1:0]          r_speed_sum;
    logic signed [TW-1:0]   r_sin_sum, r_cos_sum;
    logic [15:0]            r_speed;
    logic [14:0]            r_heading;
    logic                   r_flip;
    logic                   r_full;
    logic signed [VW-1:0]   r_x, r_y;
    logic signed [25:0]     r_z;
    logic [wsda_pkg::StageW-1:0] r_step;
    logic                   r_zero;
    logic [SW-1:0]          r_quo;
    logic [CW:0]            r_rem;
    logic [wsda_pkg::DivStepW-1:0] r_dstep;
    logic [15:0]            r_mean_speed;
    logic [14:0]            r_mean_heading;
    logic                   r_out_full;
    logic [10:0]            r_out_count;

    logic signed [15:0] a_red;
    logic               a_flip;
    logic signed [VW-1:0] dx, dy;
    logic signed [17:0] sn_q, cs_q;
    logic signed [VW-1:0] vx, vy;
    logic signed [17:0] hh;
    logic [CW:0]        rem_sh;
    logic [SW-1:0]      dividend;

    always_comb begin
        logic signed [15:0] a;
        a = signed'({1'b0, r_heading});
        if (r_heading >= wsda_pkg::FullTurn) begin
            a = a - signed'({1'b0, wsda_pkg::FullTurn});
        end
        if (a >= signed'({1'b0, wsda_pkg::HalfTurn})) begin
            a = a - signed'({1'b0, wsda_pkg::FullTurn});
        end
        a_flip = 1'b0;
        if (a > signed'({1'b0, wsda_pkg::QuarterTurn})) begin
            a = a - signed'({1'b0, wsda_pkg::HalfTurn});
            a_flip = 1'b1;
        end else if (a < -signed'({1'b0, wsda_pkg::QuarterTurn})) begin
            a = a + signed'({1'b0, wsda_pkg::HalfTurn});
            a_flip = 1'b1;
        end
        a_red = a;
    end

    assign dx = r_y >>> r_step;
    assign dy = r_x >>> r_step;

    function automatic logic signed [17:0] q15(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] q;
        q = (v + VW'(16384)) >>> 15;
        if (q > VW'(32767)) q = VW'(32767);
        if (q < -VW'(32767)) q = -VW'(32767);
        return q[17:0];
    endfunction

    always_comb begin
        sn_q = q15(r_y);
        cs_q = q15(r_x);
        if (r_flip) begin
            sn_q = -sn_q;
            cs_q = -cs_q;
        end
    end

    always_comb begin
        vx = VW'(r_cos_sum) <<< 16;
        vy = VW'(r_sin_sum) <<< 16;
    end

    always_comb begin
        logic signed [25:0] t;
        t  = (r_z + 26'sd128) >>> 8;
        hh = t[17:0];
        if (t > 26'sd11520) hh = 18'sd11520;
        if (t < -26'sd11520) hh = -18'sd11520;
    end

    assign dividend = r_speed_sum + SW'(r_count >> 1);
    assign rem_sh   = {r_rem[CW-1:0], r_quo[SW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_speed_sum <= '0;
            r_sin_sum   <= '0;
            r_cos_sum   <= '0;
            r_step      <= '0;
            r_dstep     <= '0;
            r_out_full  <= 1'b0;
            r_out_count <= '0;
        end else begin
            if (i_cmd.load) begin
                r_full    <= (r_count >= CW'(wsda_pkg::MaxSamples));
                r_speed   <= i_speed;
                r_heading <= i_heading;
            end
            if (i_cmd.rot_init) begin
                r_x    <= VW'(wsda_pkg::GainInv);
                r_y    <= '0;
                r_z    <= 26'(a_red) <<< 8;
                r_flip <= a_flip;
                r_step <= '0;
            end
            if (i_cmd.rot_step) begin
                if (r_z >= 0) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - 26'(wsda_pkg::arc(r_step));
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + 26'(wsda_pkg::arc(r_step));
                end
                r_step <= r_step + 1'b1;
            end
            if (i_cmd.accum) begin
                r_count     <= r_count + 1'b1;
                r_speed_sum <= r_speed_sum + SW'(r_speed);
                r_sin_sum   <= r_sin_sum + TW'(sn_q);
                r_cos_sum   <= r_cos_sum + TW'(cs_q);
            end
            if (i_cmd.vec_init) begin
                r_zero <= (r_sin_sum == 0) && (r_cos_sum == 0);
                r_step <= '0;
                if (vx < 0) begin
                    if (vy >= 0) begin
                        r_x <= vy;
                        r_y <= -vx;
                        r_z <= 26'sd1474560;
                    end else begin
                        r_x <= -vy;
                        r_y <= vx;
                        r_z <= -26'sd1474560;
                    end
                end else begin
                    r_x <= vx;
                    r_y <= vy;
                    r_z <= '0;
                end
            end
            if (i_cmd.vec_step) begin
                if (r_y > 0) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + 26'(wsda_pkg::arc(r_step));
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - 26'(wsda_pkg::arc(r_step));
                end
                r_step <= r_step + 1'b1;
            end
            if (i_cmd.div_init) begin
                r_quo   <= dividend;
                r_rem   <= '0;
                r_dstep <= '0;
            end
            if (i_cmd.div_step) begin
                if (rem_sh >= {1'b0, r_count}) begin
                    r_rem <= rem_sh - {1'b0, r_count};
                    r_quo <= {r_quo[SW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[SW-2:0], 1'b0};
                end
                r_dstep <= r_dstep + 1'b1;
            end
            if (i_cmd.finish) begin
                r_mean_speed   <= (r_count == 0) ? 16'd0 : r_quo[15:0];
                r_mean_heading <= r_zero ? 15'd0 : hh[14:0];
                r_out_full     <= r_full;
                r_out_count    <= 11'(r_count);
            end
        end
    end

    assign o_status.full      = r_full;
    assign o_status.last_step = (r_step == wsda_pkg::StageW'(wsda_pkg::Stages - 1));
    assign o_status.div_done  = (r_dstep == wsda_pkg::DivStepW'(SW));
    assign o_mean_speed       = r_mean_speed;
    assign o_mean_heading     = r_mean_heading;
    assign o_store_full       = r_out_full;
    assign o_sample_count     = r_out_count;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(wsda_pkg::MaxSamples))
        else $error("count above capacity");
    a_accum_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accum |=> r_count == $past(r_count) + 1'b1)
        else $error("count did not advance");
    a_no_accum_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accum |-> !r_full)
        else $error("accumulate while full");

endmodule

FILE: rtl/core/wsda_ctrl.sv
// ----------------------------------------------------------------------------
// Wind averager controller
// Sequences rotation, accumulation, vectoring and division for one request.
// ----------------------------------------------------------------------------
module wsda_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  wsda_pkg::t_status i_status,
    output wsda_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_ROT, S_ACC, S_VEC, S_DIV, S_FIN, S_OUT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   fin_go;

    assign fin_go = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:  o_cmd.load = i_in_valid;
            S_CHECK: begin
                o_cmd.rot_init = !i_status.full;
                o_cmd.vec_init = i_status.full;
            end
            S_ROT:   o_cmd.rot_step = 1'b1;
            S_ACC:   o_cmd.accum = 1'b1;
            S_OUT:   o_cmd.vec_init = 1'b1;
            S_VEC: begin
                o_cmd.vec_step = 1'b1;
                o_cmd.div_init = i_status.last_step;
            end
            S_DIV:   o_cmd.div_step = !i_status.div_done;
            S_FIN:   o_cmd.finish = fin_go;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (fin_go) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE:  if (i_in_valid) r_state <= S_CHECK;
                S_CHECK: r_state <= i_status.full ? S_VEC : S_ROT;
                S_ROT:   if (i_status.last_step) r_state <= S_ACC;
                S_ACC:   r_state <= S_OUT;
                S_OUT:   r_state <= S_VEC;
                S_VEC:   if (i_status.last_step) r_state <= S_DIV;
                S_DIV:   if (i_status.div_done) r_state <= S_FIN;
                S_FIN:   if (fin_go) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> r_state == S_CHECK)
        else $error("request not started");
    a_fin_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_valid && !i_out_ready) |=> r_state == S_FIN)
        else $error("result overwritten");
    a_vec_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VEC && i_status.last_step) |=> r_state == S_DIV)
        else $error("division not started");

endmodule

FILE: rtl/core/wind_speed_direction_averager_unit.sv
// ----------------------------------------------------------------------------
// Wind speed and direction averager
// One request per observation; one result per request with mean speed,
// circular mean direction, full flag and count.
// ----------------------------------------------------------------------------
// From acceptance to result, one shared 16-step CORDIC does the sine and
// cosine, then the atan2 of the sums, and a bit-serial divider of 26 steps
// forms the mean speed; once the store is full, rotation and accumulation
// are skipped. A new request is taken once the result is in the output
// register, while it still waits to be taken.
module wind_speed_direction_averager_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [15:0] wind_speed, [30:16] wind_heading
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // [15:0] mean_speed, [30:16] mean_heading,
                                       // [31] store_full, [42:32] sample_count
    output logic        o_unused_tie
);

    wsda_pkg::t_cmd    cmd;
    wsda_pkg::t_status status;
    logic [15:0] mean_speed;
    logic [14:0] mean_heading;
    logic        store_full;
    logic [10:0] sample_count;

    wsda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    wsda_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_speed        (s_axis_tdata[15:0]),
        .i_heading      (s_axis_tdata[30:16]),
        .o_mean_speed   (mean_speed),
        .o_mean_heading (mean_heading),
        .o_store_full   (store_full),
        .o_sample_count (sample_count)
    );

    assign m_axis_tdata = {5'd0, sample_count, store_full, mean_heading, mean_speed};
    assign o_unused_tie = ^s_axis_tdata[31];

endmodule
